[rtl/hmm_scaled_forward_step_unit_macros.svh]
// Assertion macros used by hsf_ctrl.
`ifndef HMM_SCALED_FORWARD_STEP_UNIT_MACROS_SVH
`define HMM_SCALED_FORWARD_STEP_UNIT_MACROS_SVH

// Implication checked every cycle outside reset.
`define HSF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define HSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hsf_pkg.sv]
package hsf_pkg;

    localparam int STATES_DEF    = 8;
    localparam int SYMBOLS_DEF   = 16;
    localparam int PROB_BITS_DEF = 16;

    typedef enum logic [1:0] {
        REQ_LOAD_TRANS = 2'd0,
        REQ_LOAD_EMIT  = 2'd1,
        REQ_LOAD_INIT  = 2'd2,
        REQ_OBSERVE    = 2'd3
    } req_type_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ACC_RD,
        ST_ACC_MAC,
        ST_EMIT_RD,
        ST_EMIT_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } hsf_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic clr_scale;
        logic clr_acc;
        logic acc_rd;
        logic acc_mac;
        logic emit_rd;
        logic emit_mul;
        logic div_start;
        logic out_load;
        logic out_last;
    } hsf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_observe;
        logic first;
        logic div_done;
    } hsf_status_t;

endpackage

[rtl/hsf_divider.sv]
// Restoring divider, one quotient bit per cycle.
module hsf_divider
    import hsf_pkg::*;
#(
    parameter int PROB_BITS = PROB_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [PROB_BITS-1:0]   num,
    input  logic [PROB_BITS-1:0]   den,
    output logic                   done,
    output logic [2*PROB_BITS-2:0] quot
);

    localparam int QW = 2 * PROB_BITS - 1;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]      q_reg;
    logic [PROB_BITS:0] rem_reg;
    logic [PROB_BITS-1:0] den_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [PROB_BITS+1:0] shifted;
    logic [PROB_BITS+1:0] diff;

    always_comb
    begin
        shifted = {rem_reg, q_reg[QW-1]};
        diff    = shifted - {2'b00, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= {num, {(PROB_BITS-1){1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[PROB_BITS+1])
            begin
                rem_reg <= diff[PROB_BITS:0];
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[PROB_BITS:0];
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[rtl/hsf_datapath.sv]
// Tables, shared MAC, emission multiply, scale sum, divider and output register.
module hsf_datapath
    import hsf_pkg::*;
#(
    parameter int STATES    = STATES_DEF,
    parameter int SYMBOLS   = SYMBOLS_DEF,
    parameter int PROB_BITS = PROB_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  hsf_cmd_t                   cmd,
    input  logic [$clog2(STATES)-1:0]  idx_i,
    input  logic [$clog2(STATES)-1:0]  idx_j,
    output hsf_status_t                status,
    input  logic [1:0]                 req_type,
    input  logic [2:0]                 row,
    input  logic [3:0]                 col,
    input  logic [PROB_BITS-1:0]       prob,
    input  logic [3:0]                 symbol,
    input  logic                       first,
    output logic [2:0]                 state_index,
    output logic [PROB_BITS-1:0]       alpha,
    output logic [PROB_BITS-1:0]       scale,
    output logic                       zero_scale,
    output logic                       last
);

    localparam int SW = $clog2(STATES);
    localparam int YW = $clog2(SYMBOLS);
    localparam int TW = $clog2(STATES*STATES);
    localparam int EW = $clog2(STATES*SYMBOLS);
    localparam int PW = PROB_BITS;
    localparam int FB = PROB_BITS - 1;
    localparam logic [PW-1:0] ONE = PW'(1) << FB;

    logic [PW-1:0] trans_mem [STATES*STATES];
    logic [PW-1:0] emit_mem  [STATES*SYMBOLS];
    logic [PW-1:0] init_mem  [STATES];
    logic [PW-1:0] raw_mem   [STATES];
    logic [PW-1:0] alpha_reg [STATES];
    logic [STATES-1:0] alpha_vld_reg;

    logic [1:0]    req_reg;
    logic [2:0]    row_reg;
    logic [3:0]    col_reg;
    logic [PW-1:0] prob_reg;
    logic [3:0]    sym_reg;
    logic          first_reg;

    logic [PW-1:0] trans_rd_reg;
    logic [PW-1:0] alpha_rd_reg;
    logic [PW-1:0] emit_rd_reg;
    logic [PW-1:0] init_rd_reg;
    logic [PW-1:0] raw_rd_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] scale_reg;
    logic          div_go_reg;

    logic [TW-1:0] trans_wr_idx;
    logic [TW-1:0] trans_rd_idx;
    logic [EW-1:0] emit_wr_idx;
    logic [EW-1:0] emit_rd_idx;

    logic [2*PW-1:0] prod;
    logic [PW:0]     acc_sum;
    logic [PW-1:0]   acc_src;
    logic [2*PW-1:0] eprod;
    logic [PW-1:0]   raw_val;
    logic [PW:0]     scale_sum;
    logic [PW-1:0]   prob_cl;
    logic            sym_ok;
    logic            div_done;
    logic [2*PW-2:0] quot;
    logic [PW-1:0]   alpha_q;

    logic [2:0]    out_idx_reg;
    logic [PW-1:0] out_alpha_reg;
    logic [PW-1:0] out_scale_reg;
    logic          out_zero_reg;
    logic          out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            row_reg   <= row;
            col_reg   <= col;
            prob_reg  <= prob;
            sym_reg   <= symbol;
            first_reg <= first;
        end
    end

    assign prob_cl = (prob_reg > ONE) ? ONE : prob_reg;
    assign sym_ok  = 32'(sym_reg) < SYMBOLS;

    assign trans_wr_idx = TW'(32'(row_reg) * STATES + 32'(col_reg));
    assign trans_rd_idx = TW'(32'(idx_i) * STATES + 32'(idx_j));
    assign emit_wr_idx  = EW'(32'(row_reg) * SYMBOLS + 32'(col_reg));
    assign emit_rd_idx  = EW'(32'(idx_j) * SYMBOLS + 32'(sym_reg));

    // table writes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            case (req_reg)
                REQ_LOAD_TRANS:
                    if (32'(row_reg) < STATES && 32'(col_reg) < STATES)
                        trans_mem[trans_wr_idx] <= prob_cl;
                REQ_LOAD_EMIT:
                    if (32'(row_reg) < STATES && 32'(col_reg) < SYMBOLS)
                        emit_mem[emit_wr_idx] <= prob_cl;
                REQ_LOAD_INIT:
                    if (32'(row_reg) < STATES)
                        init_mem[SW'(row_reg)] <= prob_cl;
                default: ;
            endcase
        end
    end

    // registered table reads and raw element writes
    always_ff @(posedge clk)
    begin
        if (cmd.acc_rd)
        begin
            trans_rd_reg <= trans_mem[trans_rd_idx];
            alpha_rd_reg <= alpha_vld_reg[idx_i] ? alpha_reg[idx_i] : '0;
        end
        if (cmd.emit_rd)
        begin
            emit_rd_reg <= emit_mem[emit_rd_idx];
            init_rd_reg <= init_mem[idx_j];
        end
        if (cmd.div_start)
            raw_rd_reg <= raw_mem[idx_j];
        if (cmd.emit_mul)
            raw_mem[idx_j] <= raw_val;
    end

    assign prod    = alpha_rd_reg * trans_rd_reg;
    assign acc_sum = {1'b0, acc_reg} + {1'b0, prod[FB +: PW]};
    assign acc_src = first_reg ? init_rd_reg : acc_reg;
    assign eprod   = acc_src * (sym_ok ? emit_rd_reg : PW'(0));
    assign raw_val = eprod[FB +: PW];
    assign scale_sum = {1'b0, scale_reg} + {1'b0, raw_val};

    always_ff @(posedge clk)
    begin
        if (cmd.clr_acc)
            acc_reg <= '0;
        else if (cmd.acc_mac)
            acc_reg <= (acc_sum > {1'b0, ONE}) ? ONE : acc_sum[PW-1:0];
        if (cmd.clr_scale)
            scale_reg <= '0;
        else if (cmd.emit_mul)
            scale_reg <= (scale_sum > {1'b0, ONE}) ? ONE : scale_sum[PW-1:0];
    end

    // divider starts the cycle after the raw element is read out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_go_reg <= 1'b0;
        else
            div_go_reg <= cmd.div_start;
    end

    hsf_divider #(.PROB_BITS(PROB_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (raw_rd_reg),
        .den   (scale_reg),
        .done  (div_done),
        .quot  (quot)
    );

    assign alpha_q = (scale_reg == '0) ? '0 :
                     ((quot > (2*PW-1)'(ONE)) ? ONE : quot[PW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_vld_reg <= '0;
        else if (cmd.out_load)
            alpha_vld_reg[idx_j] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            alpha_reg[idx_j] <= alpha_q;
            out_idx_reg      <= 3'(idx_j);
            out_alpha_reg    <= alpha_q;
            out_scale_reg    <= scale_reg;
            out_zero_reg     <= (scale_reg == '0);
            out_last_reg     <= cmd.out_last;
        end
    end

    assign status.is_observe = (req_reg == REQ_OBSERVE);
    assign status.first      = first_reg;
    assign status.div_done   = div_done;

    assign state_index = out_idx_reg;
    assign alpha       = out_alpha_reg;
    assign scale       = out_scale_reg;
    assign zero_scale  = out_zero_reg;
    assign last        = out_last_reg;

endmodule

[rtl/hsf_ctrl.sv]
// Sequencer for loads and the forward step.
module hsf_ctrl
    import hsf_pkg::*;
#(
    parameter int STATES = STATES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [3:0]                cfg_data,
    input  hsf_status_t               status,
    output hsf_cmd_t                  cmd,
    output logic [$clog2(STATES)-1:0] idx_i,
    output logic [$clog2(STATES)-1:0] idx_j
);

    `include "hmm_scaled_forward_step_unit_macros.svh"

    localparam int SW = $clog2(STATES);

    hsf_state_t state_reg, state_next;
    logic [SW-1:0] i_reg, i_next, j_reg, j_next;
    logic [3:0]    act_reg;
    logic          ov_reg, ov_next;
    logic [SW-1:0] last_idx;

    // clamp active state count to 2..STATES
    always_comb
    begin
        if (act_reg < 4'd2)
            last_idx = SW'(1);
        else if (32'(act_reg) > STATES)
            last_idx = SW'(STATES - 1);
        else
            last_idx = SW'(act_reg - 4'd1);
    end

    // config only between transactions; an input offered at the same time goes first
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            ov_reg    <= 1'b0;
            act_reg   <= 4'd8;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
                act_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.is_observe)
                begin
                    cmd.clr_scale = 1'b1;
                    cmd.clr_acc   = 1'b1;
                    i_next = '0;
                    j_next = '0;
                    state_next = status.first ? ST_EMIT_RD : ST_ACC_RD;
                end
                else
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ACC_RD:
            begin
                cmd.acc_rd = 1'b1;
                state_next = ST_ACC_MAC;
            end
            ST_ACC_MAC:
            begin
                cmd.acc_mac = 1'b1;
                if (i_reg == last_idx)
                    state_next = ST_EMIT_RD;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_ACC_RD;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_MUL;
            end
            ST_EMIT_MUL:
            begin
                cmd.emit_mul = 1'b1;
                cmd.clr_acc  = 1'b1;
                i_next = '0;
                if (j_reg == last_idx)
                begin
                    j_next     = '0;
                    state_next = ST_DIV_START;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = status.first ? ST_EMIT_RD : ST_ACC_RD;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait until the output register is free
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (j_reg == last_idx);
                    ov_next      = 1'b1;
                    if (j_reg == last_idx)
                        state_next = ST_IDLE;
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign idx_i     = i_reg;
    assign idx_j     = j_reg;

    `HSF_ASSERT_IMPL(a_accept_idle, clk, rst_n, in_ready, state_reg == ST_IDLE,
        "input accepted outside idle")
    `HSF_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load && ov_reg, out_ready,
        "output register overwritten")
    `HSF_ASSERT_NEXT(a_out_valid, clk, rst_n, cmd.out_load, out_valid,
        "result not presented")

endmodule

[rtl/hmm_scaled_forward_step_unit.sv]
// Scaled forward step of a discrete HMM in unsigned Q1.15. Load transactions
// (transition, emission, initial) capture the request and write one table
// entry. An observe transaction with N active states runs N*N MAC steps on the
// shared MAC (none for a first symbol, which starts from the initial table)
// and N emission multiplies, then N normalizations on a bit-serial divider
// with a 2*PROB_BITS-1 bit quotient. One result per active state comes out in
// state order through a single output register; active_states is written on
// the cfg channel while idle.
module hmm_scaled_forward_step_unit
    import hsf_pkg::*;
#(
    parameter int STATES    = STATES_DEF,
    parameter int SYMBOLS   = SYMBOLS_DEF,
    parameter int PROB_BITS = PROB_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [2:0]           row,
    input  logic [3:0]           col,
    input  logic [PROB_BITS-1:0] prob,
    input  logic [3:0]           symbol,
    input  logic                 first,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           state_index,
    output logic [PROB_BITS-1:0] alpha,
    output logic [PROB_BITS-1:0] scale,
    output logic                 zero_scale,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_data
);

    hsf_cmd_t    cmd;
    hsf_status_t status;
    logic [$clog2(STATES)-1:0] idx_i, idx_j;

    hsf_ctrl #(.STATES(STATES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .idx_i     (idx_i),
        .idx_j     (idx_j)
    );

    hsf_datapath #(
        .STATES    (STATES),
        .SYMBOLS   (SYMBOLS),
        .PROB_BITS (PROB_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .idx_i       (idx_i),
        .idx_j       (idx_j),
        .status      (status),
        .req_type    (req_type),
        .row         (row),
        .col         (col),
        .prob        (prob),
        .symbol      (symbol),
        .first       (first),
        .state_index (state_index),
        .alpha       (alpha),
        .scale       (scale),
        .zero_scale  (zero_scale),
        .last        (last)
    );

endmodule
